@@ hw/rtl/bbpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bbpe_pkg
// Types, constants and helpers shared by the bicubic Bezier patch evaluator.
// ============================================================================
package bbpe_pkg;

    // Coordinate and parameter formats
    localparam int COORD_W    = 16;
    localparam int PARAM_FRAC = 16;
    localparam int PARAM_W    = PARAM_FRAC + 1;
    localparam int NUM_PTS    = 16;
    localparam int ADDR_W     = $clog2(NUM_PTS);
    localparam int WORD_W     = 3 * COORD_W;

    // Q1.F constants
    localparam logic [PARAM_W-1:0]     ONE_Q  = PARAM_W'(1) << PARAM_FRAC;
    localparam logic [2*PARAM_W-1:0]   HALF_P = (2*PARAM_W)'(1) << (PARAM_FRAC - 1);

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Input item
    typedef struct packed {
        logic                      command;
        logic [3:0]                point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [PARAM_W-1:0]        u_pos;
        logic [PARAM_W-1:0]        v_pos;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [COORD_W-1:0] surf_x;
        logic signed [COORD_W-1:0] surf_y;
        logic signed [COORD_W-1:0] surf_z;
    } t_out;

    // Four Bernstein weights of one parameter
    typedef logic [3:0][PARAM_W-1:0] t_wgt4;

    // Control from the sequencer to the multiply-accumulate datapath
    typedef struct packed {
        logic       acc_clr;
        logic       issue;
        logic [1:0] row;
        logic [1:0] col;
        logic       fin;
    } t_mac_ctl;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WEIGHT,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Q1.F product rounded half up; both operands and result stay within 1.0
    function automatic logic [PARAM_W-1:0] rnd_mul(input logic [PARAM_W-1:0] a,
                                                   input logic [PARAM_W-1:0] b);
        logic [2*PARAM_W-1:0] p;
        p = (2*PARAM_W)'(a) * (2*PARAM_W)'(b) + HALF_P;
        return p[PARAM_FRAC +: PARAM_W];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bbpe_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bbpe_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bbpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/bbpe_wgt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bbpe_wgt
// Two-stage pipeline giving the four cubic Bernstein weights of one parameter.
// ============================================================================
module bbpe_wgt (
    input  wire logic                   i_clk,
    input  wire logic [bbpe_pkg::PARAM_W-1:0] i_t,
    output bbpe_pkg::t_wgt4             o_b
);
    import bbpe_pkg::*;

    logic [PARAM_W-1:0] tc;
    logic [PARAM_W-1:0] sc;
    logic [PARAM_W-1:0] r_t1;
    logic [PARAM_W-1:0] r_s1;
    logic [PARAM_W-1:0] r_tt;
    logic [PARAM_W-1:0] r_ss;
    logic [PARAM_W-1:0] r_ts;
    logic [PARAM_W-1:0] m1;
    logic [PARAM_W-1:0] m2;

    // Clamp to 1.0 and form the complement
    assign tc = (i_t > ONE_Q) ? ONE_Q : i_t;
    assign sc = ONE_Q - tc;

    // Stage 1: squares and cross term
    always_ff @(posedge i_clk) begin
        r_t1 <= tc;
        r_s1 <= sc;
        r_tt <= rnd_mul(tc, tc);
        r_ss <= rnd_mul(sc, sc);
        r_ts <= rnd_mul(tc, sc);
    end

    // Middle weights carry a factor of three, always below 1.0
    assign m1 = rnd_mul(r_ts, r_s1);
    assign m2 = rnd_mul(r_ts, r_t1);

    // Stage 2: cubes
    always_ff @(posedge i_clk) begin
        o_b[0] <= rnd_mul(r_ss, r_s1);
        o_b[1] <= m1 + {m1[PARAM_W-2:0], 1'b0};
        o_b[2] <= m2 + {m2[PARAM_W-2:0], 1'b0};
        o_b[3] <= rnd_mul(r_tt, r_t1);
    end

endmodule
`default_nettype wire

@@ hw/rtl/bbpe_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bbpe_mac
// Pair weight, per-coordinate product, accumulation and final rounding.
// ============================================================================
module bbpe_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bbpe_pkg::t_mac_ctl          i_ctl,
    input  wire bbpe_pkg::t_wgt4             i_wu,
    input  wire bbpe_pkg::t_wgt4             i_wv,
    input  wire logic [bbpe_pkg::WORD_W-1:0] i_rdata,
    output bbpe_pkg::t_out                   o_res,
    output logic                             o_done
);
    import bbpe_pkg::*;

    localparam int PROD_W = COORD_W + PARAM_W + 1;
    localparam int ACC_W  = PROD_W + 4;
    localparam int Q_W    = ACC_W - PARAM_FRAC;
    localparam logic [ACC_W-1:0] HALF_A = ACC_W'(1) << (PARAM_FRAC - 1);

    logic [PARAM_W-1:0]              r_w;
    logic                            r_va;
    logic                            r_vb;
    logic signed [PARAM_W:0]         w_s;
    logic signed [COORD_W-1:0]       cx;
    logic signed [COORD_W-1:0]       cy;
    logic signed [COORD_W-1:0]       cz;
    logic signed [PROD_W-1:0]        r_px;
    logic signed [PROD_W-1:0]        r_py;
    logic signed [PROD_W-1:0]        r_pz;
    logic signed [ACC_W-1:0]         r_ax;
    logic signed [ACC_W-1:0]         r_ay;
    logic signed [ACC_W-1:0]         r_az;

    // Round and saturate one accumulator to the coordinate range
    function automatic logic [COORD_W-1:0] finish(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] x;
        logic [Q_W-1:0]   q;
        x = acc + HALF_A;
        q = x[ACC_W-1:PARAM_FRAC];
        if (q[Q_W-1:COORD_W-1] == '0 || q[Q_W-1:COORD_W-1] == '1) begin
            return q[COORD_W-1:0];
        end else if (q[Q_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // Stage A: pair weight, alongside the memory read
    always_ff @(posedge i_clk) begin
        r_w <= rnd_mul(i_wu[i_ctl.row], i_wv[i_ctl.col]);
    end

    // Stage B: coordinate times pair weight
    assign w_s = $signed({1'b0, r_w});
    assign cx  = $signed(i_rdata[3*COORD_W-1:2*COORD_W]);
    assign cy  = $signed(i_rdata[2*COORD_W-1:COORD_W]);
    assign cz  = $signed(i_rdata[COORD_W-1:0]);

    always_ff @(posedge i_clk) begin
        r_px <= PROD_W'(cx) * PROD_W'(w_s);
        r_py <= PROD_W'(cy) * PROD_W'(w_s);
        r_pz <= PROD_W'(cz) * PROD_W'(w_s);
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_ctl.issue;
            r_vb <= r_va;
        end
    end

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_ax <= '0;
            r_ay <= '0;
            r_az <= '0;
        end else if (r_vb) begin
            r_ax <= r_ax + ACC_W'(r_px);
            r_ay <= r_ay + ACC_W'(r_py);
            r_az <= r_az + ACC_W'(r_pz);
        end
    end

    // Result register and strobe
    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            o_res.surf_x <= finish(r_ax);
            o_res.surf_y <= finish(r_ay);
            o_res.surf_z <= finish(r_az);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_ctl.fin;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/bicubic_bezier_patch_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Load: the sequencer stays idle, so start may be raised again in the next cycle.
// Evaluate: busy through the weight, sweep, drain and finish states after the transfer,
// result strobed in the first idle cycle; no new item is taken until then, at a pace set by the
// 16-entry sweep of the control point memory (one read port) plus weight,
// product and rounding stages. The receiver cannot stall: o_done marks a one-cycle result.
// Synchronous active-low reset returns the sequencer to idle; memory not cleared.
// ============================================================================
// bicubic_bezier_patch_eval
// Bicubic Bezier patch evaluator: control point store and sweep sequencer.
// ============================================================================
module bicubic_bezier_patch_eval (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bbpe_pkg::t_in    i_item,
    output bbpe_pkg::t_out        o_res,
    output logic                  o_done
);
    import bbpe_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_cnt;
    logic [ADDR_W-1:0]  n_cnt;
    logic [PARAM_W-1:0] r_u;
    logic [PARAM_W-1:0] r_v;
    logic               xfer;
    logic               mem_we;
    logic               mem_re;
    logic [WORD_W-1:0]  rdata;
    t_mac_ctl           ctl;
    t_wgt4              wu;
    t_wgt4              wv;

    assign xfer = start && !busy;

    // Sequencer state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (xfer && i_item.command == CMD_EVAL) n_state = S_WEIGHT;
            end
            S_WEIGHT: begin
                if (r_cnt == ADDR_W'(1)) n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (r_cnt == '1) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (r_cnt == ADDR_W'(1)) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        busy        = (r_state != S_IDLE);
        n_cnt       = (n_state != r_state) ? '0 : r_cnt + ADDR_W'(1);
        mem_we      = xfer && i_item.command == CMD_LOAD;
        mem_re      = (r_state == S_SWEEP);
        ctl.acc_clr = (r_state == S_WEIGHT);
        ctl.issue   = (r_state == S_SWEEP);
        ctl.row     = r_cnt[3:2];
        ctl.col     = r_cnt[1:0];
        ctl.fin     = (r_state == S_FINISH);
    end

    // Surface parameters held for the whole evaluation
    always_ff @(posedge i_clk) begin
        if (xfer && i_item.command == CMD_EVAL) begin
            r_u <= i_item.u_pos;
            r_v <= i_item.v_pos;
        end
    end

    // Control point store: x, y, z packed into one word
    bbpe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_PTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_item.point_index),
        .i_wdata ({i_item.point_x, i_item.point_y, i_item.point_z}),
        .i_re    (mem_re),
        .i_raddr (r_cnt),
        .o_rdata (rdata)
    );

    // Weights for u (rows) and v (columns)
    bbpe_wgt u_wgt_u (
        .i_clk (i_clk),
        .i_t   (r_u),
        .o_b   (wu)
    );

    bbpe_wgt u_wgt_v (
        .i_clk (i_clk),
        .i_t   (r_v),
        .o_b   (wv)
    );

    // Multiply-accumulate and rounding
    bbpe_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_wu    (wu),
        .i_wv    (wv),
        .i_rdata (rdata),
        .o_res   (o_res),
        .o_done  (o_done)
    );

    // An evaluate transfer starts the weight stage
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && i_item.command == CMD_EVAL) |=> (r_state == S_WEIGHT && r_cnt == '0))
        else $error("evaluate transfer did not start weight stage");

    // Sweep always begins at the first control point
    a_sweep_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SWEEP) |-> (r_cnt == '0))
        else $error("sweep did not start at entry zero");

    // Result strobe follows the finish step and nothing else
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> (o_done && r_state == S_IDLE))
        else $error("no result after finish step");

    a_done_only_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_FINISH))
        else $error("result strobe outside finish");

    // No memory write while an evaluation reads the store
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP || r_state == S_DRAIN) |-> !mem_we)
        else $error("store written during evaluation");

endmodule
`default_nettype wire

@@ tb/sv/bicubic_bezier_patch_eval_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bicubic_bezier_patch_eval_tb
// Self-checking bench for the bicubic Bezier patch evaluator. A short table
// first fills the control point store and probes the patch corners and
// out-of-range parameters. Random patch reloads and evaluations follow, under
// several sender idling rates. Every surface point is checked against a
// bit-exact fixed-point Bernstein predictor held in the bench.
// ============================================================================
module bicubic_bezier_patch_eval_tb;
    import bbpe_pkg::*;

    localparam int             DIR_ROWS    = 24;
    localparam int             ITEMS_TOTAL = 1250;
    localparam int             STALL_LIMIT = 1000;
    localparam int             SETTLE_CYC  = 40;
    localparam longint unsigned UNIT_Q     = 64'd1 << PARAM_FRAC;
    localparam longint unsigned HALF_Q     = UNIT_Q >> 1;
    localparam longint         SURF_MAX    = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint         SURF_MIN    = -SURF_MAX - 1;

    // One row of the directed table; res is used only where typed is set
    typedef struct packed {
        t_in  item;
        logic typed;
        t_out res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    t_out o_res;
    logic o_done;

    // Bench copy of the control point store, and the surface points still due
    logic signed [COORD_W-1:0] ctrl_pts [NUM_PTS][3];
    t_out                      surf_due [$];
    t_stim_row                 dir_tab  [DIR_ROWS];

    int   err_cnt;
    int   items_sent;
    int   gap_pct;
    int   stall_cnt;
    t_out want;

    bicubic_bezier_patch_eval uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_res   (o_res),
        .o_done  (o_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point Bernstein predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned q_mul(input longint unsigned a,
                                              input longint unsigned b);
        return (a * b + HALF_Q) >> PARAM_FRAC;
    endfunction

    // Cubic weights of one parameter; anything above one counts as one
    function automatic t_wgt4 bern_weights(input logic [PARAM_W-1:0] raw);
        longint unsigned t, s, tt, ss, ts;
        t_wgt4           w;
        t  = (raw > ONE_Q) ? UNIT_Q : longint'(raw);
        s  = UNIT_Q - t;
        tt = q_mul(t, t);
        ss = q_mul(s, s);
        ts = q_mul(t, s);
        w[0] = PARAM_W'(q_mul(ss, s));
        w[1] = PARAM_W'(3 * q_mul(ts, s));
        w[2] = PARAM_W'(3 * q_mul(ts, t));
        w[3] = PARAM_W'(q_mul(tt, t));
        return w;
    endfunction

    function automatic t_out eval_patch(input logic [PARAM_W-1:0] u,
                                        input logic [PARAM_W-1:0] v);
        t_wgt4                     wu, wv;
        longint                    acc [3];
        longint                    w, x, q;
        logic signed [COORD_W-1:0] sat [3];
        t_out                      res;
        wu  = bern_weights(u);
        wv  = bern_weights(v);
        acc = '{0, 0, 0};
        // row follows u, column follows v
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w = longint'(q_mul(wu[r], wv[c]));
                for (int k = 0; k < 3; k++) begin
                    acc[k] += longint'(ctrl_pts[r*4 + c][k]) * w;
                end
            end
        end
        // round half up (floor after adding half), then saturate
        for (int k = 0; k < 3; k++) begin
            x = acc[k] + longint'(HALF_Q);
            q = x >>> PARAM_FRAC;
            if (q > SURF_MAX) q = SURF_MAX;
            if (q < SURF_MIN) q = SURF_MIN;
            sat[k] = COORD_W'(q);
        end
        res.surf_x = sat[0];
        res.surf_y = sat[1];
        res.surf_z = sat[2];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders; the fields a command ignores are filled with junk
    // ------------------------------------------------------------------------
    function automatic t_in make_load(input logic [3:0] idx, input int x, input int y,
                                      input int z);
        t_in it;
        it.command     = CMD_LOAD;
        it.point_index = idx;
        it.point_x     = COORD_W'(x);
        it.point_y     = COORD_W'(y);
        it.point_z     = COORD_W'(z);
        it.u_pos       = PARAM_W'($urandom);
        it.v_pos       = PARAM_W'($urandom);
        return it;
    endfunction

    function automatic t_in make_eval(input int u, input int v);
        t_in it;
        it.command     = CMD_EVAL;
        it.point_index = 4'($urandom);
        it.point_x     = COORD_W'($urandom);
        it.point_y     = COORD_W'($urandom);
        it.point_z     = COORD_W'($urandom);
        it.u_pos       = PARAM_W'(u);
        it.v_pos       = PARAM_W'(v);
        return it;
    endfunction

    function automatic t_stim_row load_row(input logic [3:0] idx, input int x, input int y,
                                           input int z);
        t_stim_row row;
        row.item  = make_load(idx, x, y, z);
        row.typed = 1'b0;
        row.res   = '0;
        return row;
    endfunction

    function automatic t_stim_row eval_row(input int u, input int v, input logic typed,
                                           input int x, input int y, input int z);
        t_stim_row row;
        row.item       = make_eval(u, v);
        row.typed      = typed;
        row.res.surf_x = COORD_W'(x);
        row.res.surf_y = COORD_W'(y);
        row.res.surf_z = COORD_W'(z);
        return row;
    endfunction

    // Coordinates lean on the extremes
    function automatic int rand_coord();
        case ($urandom_range(7))
            0: return 32767;
            1: return -32768;
            2: return 0;
            3: return -1;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // Parameters: ends of the range, just inside them, above one, or anywhere
    function automatic int rand_param();
        case ($urandom_range(9))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(131071, 65537);
            3: return $urandom_range(255);
            4: return 65536 - $urandom_range(255);
            default: return $urandom_range(65536);
        endcase
    endfunction

    // style 0: all most positive, 1: all most negative, else random
    function automatic int style_coord(input int style);
        case (style)
            0: return 32767;
            1: return -32768;
            default: return rand_coord();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one transfer, prediction on acceptance, then an optional gap
    // ------------------------------------------------------------------------
    task automatic issue_item(input t_in it, input logic typed, input t_out res);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (it.command == CMD_LOAD) begin
            ctrl_pts[it.point_index][0] = it.point_x;
            ctrl_pts[it.point_index][1] = it.point_y;
            ctrl_pts[it.point_index][2] = it.point_z;
        end else begin
            surf_due.push_back(typed ? res : eval_patch(it.u_pos, it.v_pos));
        end
        items_sent++;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker; results cannot be held off, so sample on every strobe
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (surf_due.size() == 0) begin
                $error("surface point with none due: x %0d y %0d z %0d",
                       o_res.surf_x, o_res.surf_y, o_res.surf_z);
                err_cnt++;
            end else begin
                want = surf_due.pop_front();
                if (o_res.surf_x !== want.surf_x) begin
                    $error("surf_x: expected %0d, got %0d", want.surf_x, o_res.surf_x);
                    err_cnt++;
                end
                if (o_res.surf_y !== want.surf_y) begin
                    $error("surf_y: expected %0d, got %0d", want.surf_y, o_res.surf_y);
                    err_cnt++;
                end
                if (o_res.surf_z !== want.surf_z) begin
                    $error("surf_z: expected %0d, got %0d", want.surf_z, o_res.surf_z);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("bicubic_bezier_patch_eval: mismatch");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int pct_tab [4];
        int style, base, step;

        pct_tab    = '{0, 63, 0, 31};
        err_cnt    = 0;
        items_sent = 0;
        gap_pct    = 0;
        stall_cnt  = 0;
        for (int i = 0; i < NUM_PTS; i++) ctrl_pts[i] = '{'0, '0, '0};

        // Corner points carry the extremes so the corner probes read them back
        dir_tab = '{
            load_row(4'd0,   32767, -32768,      0),
            load_row(4'd1,    1000,   2000,  -3000),
            load_row(4'd2,   -1234,   4321,   7777),
            load_row(4'd3,  -32768,  32767,     -1),
            load_row(4'd4,   12345, -12345,    256),
            load_row(4'd5,  -20000,  15000,     -7),
            load_row(4'd6,     300,   -300,  30000),
            load_row(4'd7,      -1,      1, -16384),
            load_row(4'd8,   16384, -16385,   8191),
            load_row(4'd9,   -8192,   4095,  -4096),
            load_row(4'd10,      2,     -2,    100),
            load_row(4'd11, -30000,  29999, -29999),
            load_row(4'd12,      1,     -1,  32767),
            load_row(4'd13,    500,    600,   -700),
            load_row(4'd14, -32767,  32766,     42),
            load_row(4'd15,     -1,      0, -32768),
            // corners of the patch
            eval_row(0,      0,      1'b1,  32767, -32768,      0),
            eval_row(0,      65536,  1'b1, -32768,  32767,     -1),
            eval_row(65536,  0,      1'b1,      1,     -1,  32767),
            eval_row(65536,  65536,  1'b1,     -1,      0, -32768),
            // parameters above one are taken as one
            eval_row(131071, 131071, 1'b1,     -1,      0, -32768),
            eval_row(65537,  0,      1'b1,      1,     -1,  32767),
            // interior points
            eval_row(32768,  32768,  1'b0,      0,      0,      0),
            eval_row(21845,  43690,  1'b0,      0,      0,      0)
        };

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            issue_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
        end

        // Random phases: whole patch reloads followed by evaluations, plus
        // stray single loads and evaluations
        for (int p = 0; p < 4; p++) begin
            gap_pct = pct_tab[p];
            while (items_sent < DIR_ROWS + (p + 1) * (ITEMS_TOTAL - DIR_ROWS) / 4) begin
                if ($urandom_range(99) < 25) begin
                    style = $urandom_range(3);
                    base  = $urandom_range(15);
                    step  = 2 * $urandom_range(7) + 1;
                    for (int i = 0; i < NUM_PTS; i++) begin
                        issue_item(make_load(4'((base + i * step) & 15), style_coord(style),
                                             style_coord(style), style_coord(style)),
                                   1'b0, '0);
                    end
                    repeat ($urandom_range(6, 1)) begin
                        issue_item(make_eval(rand_param(), rand_param()), 1'b0, '0);
                    end
                end else if ($urandom_range(1) == 0) begin
                    issue_item(make_load(4'($urandom), rand_coord(), rand_coord(),
                                         rand_coord()), 1'b0, '0);
                end else begin
                    issue_item(make_eval(rand_param(), rand_param()), 1'b0, '0);
                end
            end
        end
        start <= 1'b0;

        // Drain outstanding evaluations, then watch for strays
        while (surf_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (err_cnt == 0 && surf_due.size() == 0) begin
            $display("bicubic_bezier_patch_eval: match");
        end else begin
            $display("bicubic_bezier_patch_eval: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bbpe_pkg.sv
hw/rtl/bbpe_ram.sv
hw/rtl/bbpe_wgt.sv
hw/rtl/bbpe_mac.sv
hw/rtl/bicubic_bezier_patch_eval.sv
tb/sv/bicubic_bezier_patch_eval_tb.sv
